>>> rtl/kscd_pkg.sv
// ----------------------------------------------------------------------------
// kscd_pkg - shared types and tables for the scan code set 1 decoder
// Event kinds, arrow directions, scan code values, state and result
// records, and the character lookup tables.
// ----------------------------------------------------------------------------
`default_nettype none

package kscd_pkg;

   // Number of scan codes covered by the character map
   localparam int unsigned KSCD_MAP_ENTRIES = 58;

   // Last map index of the number row, where caps lock has no effect
   localparam logic [6:0] NUM_ROW_LAST = 7'd13;

   // Event kinds carried on the response channel
   typedef enum logic [2:0] {
      KIND_CHAR    = 3'd0,
      KIND_ARROW   = 3'd1,
      KIND_NUMLOCK = 3'd2,
      KIND_UNKNOWN = 3'd3,
      KIND_BEYOND  = 3'd4
   } kind_type;

   // Arrow directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   // Scan code values (set 1)
   localparam logic [7:0] SC_PREFIX      = 8'hE0;
   localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
   localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
   localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
   localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
   localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
   localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
   localparam logic [7:0] SC_NUMLOCK     = 8'h45;
   localparam logic [7:0] SC_LCMD_MAKE   = 8'h5B;
   localparam logic [7:0] SC_RCMD_MAKE   = 8'h5C;
   localparam logic [7:0] SC_LCMD_BRK    = 8'hDB;
   localparam logic [7:0] SC_RCMD_BRK    = 8'hDC;
   localparam logic [7:0] SC_UP_MAKE     = 8'h48;
   localparam logic [7:0] SC_LEFT_MAKE   = 8'h4B;
   localparam logic [7:0] SC_RIGHT_MAKE  = 8'h4D;
   localparam logic [7:0] SC_DOWN_MAKE   = 8'h50;
   localparam logic [7:0] SC_UP_BRK      = 8'hC8;
   localparam logic [7:0] SC_LEFT_BRK    = 8'hCB;
   localparam logic [7:0] SC_RIGHT_BRK   = 8'hCD;
   localparam logic [7:0] SC_DOWN_BRK    = 8'hD0;

   // Modifier and prefix state
   typedef struct packed {
      logic [1:0] shift_count;
      logic [1:0] ctrl_count;
      logic [1:0] cmd_count;
      logic       alt_flag;
      logic       caps_flag;
      logic       prefix_pending;
   } state_type;

   // Decode outcome for one request
   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [6:0] char_code;
      logic [1:0] arrow_dir;
   } result_type;

   // Unshifted character table
   function automatic logic [6:0] plain_char(input logic [6:0] idx);
      logic [6:0] ch;
      case (idx)
         7'd1:  ch = 7'h1B; // escape
         7'd2:  ch = 7'h31; // 1
         7'd3:  ch = 7'h32;
         7'd4:  ch = 7'h33;
         7'd5:  ch = 7'h34;
         7'd6:  ch = 7'h35;
         7'd7:  ch = 7'h36;
         7'd8:  ch = 7'h37;
         7'd9:  ch = 7'h38;
         7'd10: ch = 7'h39;
         7'd11: ch = 7'h30; // 0
         7'd12: ch = 7'h2D; // -
         7'd13: ch = 7'h3D; // =
         7'd14: ch = 7'h08; // backspace
         7'd15: ch = 7'h09; // tab
         7'd16: ch = 7'h71; // q
         7'd17: ch = 7'h77;
         7'd18: ch = 7'h65;
         7'd19: ch = 7'h72;
         7'd20: ch = 7'h74;
         7'd21: ch = 7'h79;
         7'd22: ch = 7'h75;
         7'd23: ch = 7'h69;
         7'd24: ch = 7'h6F;
         7'd25: ch = 7'h70; // p
         7'd26: ch = 7'h5B; // [
         7'd27: ch = 7'h5D; // ]
         7'd28: ch = 7'h0A; // enter
         7'd30: ch = 7'h61; // a
         7'd31: ch = 7'h73;
         7'd32: ch = 7'h64;
         7'd33: ch = 7'h66;
         7'd34: ch = 7'h67;
         7'd35: ch = 7'h68;
         7'd36: ch = 7'h6A;
         7'd37: ch = 7'h6B;
         7'd38: ch = 7'h6C; // l
         7'd39: ch = 7'h3B; // ;
         7'd40: ch = 7'h27; // '
         7'd41: ch = 7'h60; // `
         7'd43: ch = 7'h5C; // backslash
         7'd44: ch = 7'h7A; // z
         7'd45: ch = 7'h78;
         7'd46: ch = 7'h63;
         7'd47: ch = 7'h76;
         7'd48: ch = 7'h62;
         7'd49: ch = 7'h6E;
         7'd50: ch = 7'h6D; // m
         7'd51: ch = 7'h2C; // ,
         7'd52: ch = 7'h2E; // .
         7'd53: ch = 7'h2F; // /
         7'd57: ch = 7'h20; // space
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Shifted character table
   function automatic logic [6:0] shift_char(input logic [6:0] idx);
      logic [6:0] ch;
      case (idx)
         7'd1:  ch = 7'h1B;
         7'd2:  ch = 7'h21; // !
         7'd3:  ch = 7'h40; // @
         7'd4:  ch = 7'h23; // #
         7'd5:  ch = 7'h24; // $
         7'd6:  ch = 7'h25; // %
         7'd7:  ch = 7'h5E; // ^
         7'd8:  ch = 7'h26; // &
         7'd9:  ch = 7'h2A; // *
         7'd10: ch = 7'h28; // (
         7'd11: ch = 7'h29; // )
         7'd12: ch = 7'h5F; // _
         7'd13: ch = 7'h2B; // +
         7'd14: ch = 7'h08;
         7'd15: ch = 7'h09;
         7'd16: ch = 7'h51; // Q
         7'd17: ch = 7'h57;
         7'd18: ch = 7'h45;
         7'd19: ch = 7'h52;
         7'd20: ch = 7'h54;
         7'd21: ch = 7'h59;
         7'd22: ch = 7'h55;
         7'd23: ch = 7'h49;
         7'd24: ch = 7'h4F;
         7'd25: ch = 7'h50; // P
         7'd26: ch = 7'h7B; // {
         7'd27: ch = 7'h7D; // }
         7'd28: ch = 7'h0A;
         7'd30: ch = 7'h41; // A
         7'd31: ch = 7'h53;
         7'd32: ch = 7'h44;
         7'd33: ch = 7'h46;
         7'd34: ch = 7'h47;
         7'd35: ch = 7'h48;
         7'd36: ch = 7'h4A;
         7'd37: ch = 7'h4B;
         7'd38: ch = 7'h4C; // L
         7'd39: ch = 7'h3A; // :
         7'd40: ch = 7'h22; // "
         7'd41: ch = 7'h7E; // ~
         7'd43: ch = 7'h7C; // |
         7'd44: ch = 7'h5A; // Z
         7'd45: ch = 7'h58;
         7'd46: ch = 7'h43;
         7'd47: ch = 7'h56;
         7'd48: ch = 7'h42;
         7'd49: ch = 7'h4E;
         7'd50: ch = 7'h4D; // M
         7'd51: ch = 7'h3C; // <
         7'd52: ch = 7'h3E; // >
         7'd53: ch = 7'h3F; // ?
         7'd57: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Caps lock table: number row as plain, everything else as shifted
   function automatic logic [6:0] caps_char(input logic [6:0] idx);
      return (idx <= NUM_ROW_LAST) ? plain_char(idx) : shift_char(idx);
   endfunction

endpackage

`default_nettype wire

>>> rtl/kscd_decode.sv
// ----------------------------------------------------------------------------
// kscd_decode - one-byte scan code decode step
// Works out the next modifier/prefix state and the event, if any, that a
// single scan byte produces from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module kscd_decode #(
   parameter int unsigned MAP_ENTRIES = kscd_pkg::KSCD_MAP_ENTRIES
) (
   input  wire logic [7:0]          scan_byte,
   input  wire kscd_pkg::state_type cur_state,
   output kscd_pkg::state_type      nxt_state,
   output kscd_pkg::result_type     result
);

   logic       beyond_map;
   logic [6:0] idx;

   assign idx        = scan_byte[6:0];
   assign beyond_map = ({1'b0, idx} >= 8'(MAP_ENTRIES));

   // Prefix handling, modifier tracking and event selection
   always_comb begin
      nxt_state        = cur_state;
      result.emit      = 1'b0;
      result.kind      = kscd_pkg::KIND_CHAR;
      result.char_code = 7'd0;
      result.arrow_dir = kscd_pkg::DIR_UP;

      if (cur_state.prefix_pending) begin
         // extended codes after an E0 prefix
         nxt_state.prefix_pending = 1'b0;
         unique case (scan_byte) inside
            kscd_pkg::SC_LCMD_MAKE, kscd_pkg::SC_RCMD_MAKE: begin
               nxt_state.cmd_count = cur_state.cmd_count + 2'd1;
            end
            kscd_pkg::SC_LCMD_BRK, kscd_pkg::SC_RCMD_BRK: begin
               nxt_state.cmd_count = cur_state.cmd_count - 2'd1;
            end
            kscd_pkg::SC_CTRL_MAKE: begin
               nxt_state.ctrl_count = cur_state.ctrl_count + 2'd1;
            end
            kscd_pkg::SC_CTRL_BRK: begin
               nxt_state.ctrl_count = cur_state.ctrl_count - 2'd1;
            end
            kscd_pkg::SC_UP_MAKE: begin
               result.emit      = 1'b1;
               result.kind      = kscd_pkg::KIND_ARROW;
               result.arrow_dir = kscd_pkg::DIR_UP;
            end
            kscd_pkg::SC_LEFT_MAKE: begin
               result.emit      = 1'b1;
               result.kind      = kscd_pkg::KIND_ARROW;
               result.arrow_dir = kscd_pkg::DIR_LEFT;
            end
            kscd_pkg::SC_RIGHT_MAKE: begin
               result.emit      = 1'b1;
               result.kind      = kscd_pkg::KIND_ARROW;
               result.arrow_dir = kscd_pkg::DIR_RIGHT;
            end
            kscd_pkg::SC_DOWN_MAKE: begin
               result.emit      = 1'b1;
               result.kind      = kscd_pkg::KIND_ARROW;
               result.arrow_dir = kscd_pkg::DIR_DOWN;
            end
            kscd_pkg::SC_UP_BRK, kscd_pkg::SC_LEFT_BRK,
            kscd_pkg::SC_RIGHT_BRK, kscd_pkg::SC_DOWN_BRK: begin
               // arrow releases are dropped
            end
            default: begin
               result.emit = 1'b1;
               result.kind = kscd_pkg::KIND_UNKNOWN;
            end
         endcase
      end else begin
         // plain codes
         unique case (scan_byte) inside
            kscd_pkg::SC_PREFIX: begin
               nxt_state.prefix_pending = 1'b1;
            end
            kscd_pkg::SC_CTRL_MAKE: begin
               nxt_state.ctrl_count = cur_state.ctrl_count + 2'd1;
            end
            kscd_pkg::SC_CTRL_BRK: begin
               nxt_state.ctrl_count = cur_state.ctrl_count - 2'd1;
            end
            kscd_pkg::SC_LSHIFT_MAKE, kscd_pkg::SC_RSHIFT_MAKE: begin
               nxt_state.shift_count = cur_state.shift_count + 2'd1;
            end
            kscd_pkg::SC_LSHIFT_BRK, kscd_pkg::SC_RSHIFT_BRK: begin
               nxt_state.shift_count = cur_state.shift_count - 2'd1;
            end
            kscd_pkg::SC_ALT_MAKE: begin
               nxt_state.alt_flag = 1'b1;
            end
            kscd_pkg::SC_ALT_BRK: begin
               nxt_state.alt_flag = 1'b0;
            end
            kscd_pkg::SC_CAPS_MAKE: begin
               nxt_state.caps_flag = ~cur_state.caps_flag;
            end
            kscd_pkg::SC_NUMLOCK: begin
               result.emit = 1'b1;
               result.kind = kscd_pkg::KIND_NUMLOCK;
            end
            default: begin
               // releases and the acknowledge byte give nothing
               if (!scan_byte[7]) begin
                  result.emit = 1'b1;
                  if (beyond_map) begin
                     result.kind = kscd_pkg::KIND_BEYOND;
                  end else if (cur_state.shift_count != 2'd0) begin
                     result.char_code = kscd_pkg::shift_char(idx);
                  end else if (cur_state.caps_flag) begin
                     result.char_code = kscd_pkg::caps_char(idx);
                  end else begin
                     result.char_code = kscd_pkg::plain_char(idx);
                  end
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/keyboard_scan_code_decoder.sv
// ----------------------------------------------------------------------------
// keyboard_scan_code_decoder - PC scan code set 1 decoder
// Turns raw keyboard scan bytes into character, arrow and status events.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_scan_byte) carries one scan
//   byte per request. Response channel (rsp_valid / rsp_stall / rsp_*)
//   carries at most one event per request, in request order.
//   Modifier presses and releases, key releases, the acknowledge byte and
//   the E0 prefix only update internal state and produce no response.
//   Path: a taken request waits in the input register and is decoded from it;
//   its event is captured in the response register once that register is free.
//   Throughput: one request per cycle unless rsp_stall holds a response,
//   set by the single decode step between the input and response registers.
//   Stall: while a response is held by rsp_stall, the next request waits in
//   the input register and req_stall rises only once that register is full.
//   Reset (synchronous, active high) clears the modifier counts, alt and caps
//   flags, the pending prefix and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scan_code_decoder #(
   parameter int unsigned MAP_ENTRIES = kscd_pkg::KSCD_MAP_ENTRIES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_scan_byte,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_event_kind,
   output logic [6:0]      rsp_char_code,
   output logic [1:0]      rsp_arrow_dir,
   output logic            rsp_shift_active,
   output logic            rsp_ctrl_active,
   output logic            rsp_alt_active,
   output logic            rsp_cmd_active,
   output logic            rsp_caps_active,
   output logic [7:0]      rsp_raw_code
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           scan_ff;
   kscd_pkg::state_type  state_ff, state_in;
   kscd_pkg::result_type dec_result;
   logic                 advance;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           kind_ff;
   logic [6:0]           char_ff;
   logic [1:0]           dir_ff;
   logic [7:0]           raw_ff;
   kscd_pkg::state_type  flags_ff;

   // Decode step
   kscd_decode #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_decode (
      .scan_byte (scan_ff),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .result    (dec_result)
   );

   // Flow control: the held byte moves on once the response register is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && dec_result.emit) || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         scan_ff <= req_scan_byte;
      end
   end

   // Response register, flags as they stand after the byte
   always_ff @(posedge clock) begin
      if (advance && dec_result.emit) begin
         kind_ff  <= dec_result.kind;
         char_ff  <= dec_result.char_code;
         dir_ff   <= dec_result.arrow_dir;
         raw_ff   <= scan_ff;
         flags_ff <= state_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_char_code    = char_ff;
   assign rsp_arrow_dir    = dir_ff;
   assign rsp_shift_active = (flags_ff.shift_count != 2'd0);
   assign rsp_ctrl_active  = (flags_ff.ctrl_count != 2'd0);
   assign rsp_alt_active   = flags_ff.alt_flag;
   assign rsp_cmd_active   = (flags_ff.cmd_count != 2'd0);
   assign rsp_caps_active  = flags_ff.caps_flag;
   assign rsp_raw_code     = raw_ff;

`ifndef ASSERT_OFF
   // Back-pressure only when both registers are occupied and the output stalls
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a held response");

   // A prefix byte taken without a pending prefix arms the prefix
   a_prefix_arm: assert property (@(posedge clock) disable iff (reset)
      (advance && !state_ff.prefix_pending && scan_ff == kscd_pkg::SC_PREFIX)
      |=> state_ff.prefix_pending)
      else $error("E0 prefix not recorded");

   // Bytes with the top bit set outside a prefix never produce a response
   a_break_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && !state_ff.prefix_pending && scan_ff[7]) |=> !rsp_valid_ff)
      else $error("release or acknowledge byte produced a response");

   // Only character events carry a character
   a_char_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != kscd_pkg::KIND_CHAR) |-> (char_ff == 7'd0))
      else $error("non-character event with character code");

   // Arrow direction only on arrow events
   a_dir_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != kscd_pkg::KIND_ARROW) |-> (dir_ff == kscd_pkg::DIR_UP))
      else $error("arrow direction on non-arrow event");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - keyboard scan code decoder check
// Drives scan bytes through the request channel with random gaps, holds the
// response channel off at random, and checks each event against a decoder
// model that tracks the prefix, the hold counts, the alt and caps flags.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAP_SIZE        = kscd_pkg::KSCD_MAP_ENTRIES;
   localparam logic [7:0]  SC_ACK          = 8'hFA;
   localparam logic [7:0]  RELEASE_BIT     = 8'h80;
   localparam int unsigned RANDOM_BYTES    = 1500;
   localparam int unsigned PHASE_BYTES     = 150;
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned DRAIN_CYCLES    = 12;
   localparam int unsigned CYCLE_LIMIT     = 600000;

   // One decoded key event as seen on the response channel
   typedef struct packed {
      kscd_pkg::kind_type kind;
      logic [6:0]         char_code;
      logic [1:0]         arrow_dir;
      logic               shift_on;
      logic               ctrl_on;
      logic               alt_on;
      logic               cmd_on;
      logic               caps_on;
      logic [7:0]         raw_code;
   } key_event_type;

   // Decoder state tracking and the queue of events still to arrive
   class key_event_tracker_type;
      key_event_type pending_events[$];
      int unsigned   mismatch_count = 0;
      logic [1:0]    shift_holds = 2'd0;
      logic [1:0]    ctrl_holds = 2'd0;
      logic [1:0]    cmd_holds = 2'd0;
      logic          alt_down = 1'b0;
      logic          caps_locked = 1'b0;
      logic          after_prefix = 1'b0;

      logic [6:0] plain_map [0:57] = '{
         'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38, 'h39, 'h30,
         'h2D, 'h3D, 'h08, 'h09, 'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69,
         'h6F, 'h70, 'h5B, 'h5D, 'h0A, 'h00, 'h61, 'h73, 'h64, 'h66, 'h67, 'h68,
         'h6A, 'h6B, 'h6C, 'h3B, 'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76,
         'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h00, 'h00, 'h20};
      logic [6:0] shifted_map [0:57] = '{
         'h00, 'h1B, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5E, 'h26, 'h2A, 'h28, 'h29,
         'h5F, 'h2B, 'h08, 'h09, 'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
         'h4F, 'h50, 'h7B, 'h7D, 'h0A, 'h00, 'h41, 'h53, 'h44, 'h46, 'h47, 'h48,
         'h4A, 'h4B, 'h4C, 'h3A, 'h22, 'h7E, 'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56,
         'h42, 'h4E, 'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h00, 'h00, 'h20};
      // caps lock: number row stays plain, letters and punctuation shift
      logic [6:0] caps_map [0:57] = '{
         'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38, 'h39, 'h30,
         'h2D, 'h3D, 'h08, 'h09, 'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
         'h4F, 'h50, 'h7B, 'h7D, 'h0A, 'h00, 'h41, 'h53, 'h44, 'h46, 'h47, 'h48,
         'h4A, 'h4B, 'h4C, 'h3A, 'h22, 'h7E, 'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56,
         'h42, 'h4E, 'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h00, 'h00, 'h20};

      // Flags are taken after the byte has updated the state
      function void push_event(input kscd_pkg::kind_type kind, input logic [6:0] ch,
                               input logic [1:0] dir, input logic [7:0] code);
         key_event_type ev;
         ev.kind      = kind;
         ev.char_code = ch;
         ev.arrow_dir = dir;
         ev.shift_on  = (shift_holds != 2'd0);
         ev.ctrl_on   = (ctrl_holds != 2'd0);
         ev.alt_on    = alt_down;
         ev.cmd_on    = (cmd_holds != 2'd0);
         ev.caps_on   = caps_locked;
         ev.raw_code  = code;
         pending_events.push_back(ev);
      endfunction

      // Accepted request: update state, queue the event it causes
      function void predict_scan_byte(input logic [7:0] code);
         logic [6:0] ch;
         if (after_prefix) begin
            after_prefix = 1'b0;
            case (code)
               kscd_pkg::SC_LCMD_MAKE, kscd_pkg::SC_RCMD_MAKE:
                  cmd_holds = cmd_holds + 2'd1;
               kscd_pkg::SC_LCMD_BRK, kscd_pkg::SC_RCMD_BRK:
                  cmd_holds = cmd_holds - 2'd1;
               kscd_pkg::SC_CTRL_MAKE: ctrl_holds = ctrl_holds + 2'd1;
               kscd_pkg::SC_CTRL_BRK:  ctrl_holds = ctrl_holds - 2'd1;
               kscd_pkg::SC_UP_MAKE:
                  push_event(kscd_pkg::KIND_ARROW, 7'd0, kscd_pkg::DIR_UP, code);
               kscd_pkg::SC_LEFT_MAKE:
                  push_event(kscd_pkg::KIND_ARROW, 7'd0, kscd_pkg::DIR_LEFT, code);
               kscd_pkg::SC_RIGHT_MAKE:
                  push_event(kscd_pkg::KIND_ARROW, 7'd0, kscd_pkg::DIR_RIGHT, code);
               kscd_pkg::SC_DOWN_MAKE:
                  push_event(kscd_pkg::KIND_ARROW, 7'd0, kscd_pkg::DIR_DOWN, code);
               kscd_pkg::SC_UP_BRK, kscd_pkg::SC_LEFT_BRK,
               kscd_pkg::SC_RIGHT_BRK, kscd_pkg::SC_DOWN_BRK: ;
               default:
                  push_event(kscd_pkg::KIND_UNKNOWN, 7'd0, kscd_pkg::DIR_UP, code);
            endcase
         end else begin
            case (code)
               kscd_pkg::SC_PREFIX:    after_prefix = 1'b1;
               kscd_pkg::SC_CTRL_MAKE: ctrl_holds = ctrl_holds + 2'd1;
               kscd_pkg::SC_CTRL_BRK:  ctrl_holds = ctrl_holds - 2'd1;
               kscd_pkg::SC_LSHIFT_MAKE, kscd_pkg::SC_RSHIFT_MAKE:
                  shift_holds = shift_holds + 2'd1;
               kscd_pkg::SC_LSHIFT_BRK, kscd_pkg::SC_RSHIFT_BRK:
                  shift_holds = shift_holds - 2'd1;
               kscd_pkg::SC_ALT_MAKE:  alt_down = 1'b1;
               kscd_pkg::SC_ALT_BRK:   alt_down = 1'b0;
               kscd_pkg::SC_CAPS_MAKE: caps_locked = !caps_locked;
               kscd_pkg::SC_NUMLOCK:
                  push_event(kscd_pkg::KIND_NUMLOCK, 7'd0, kscd_pkg::DIR_UP, code);
               default: begin
                  // releases and the acknowledge byte are dropped
                  if (code[7]) begin
                  end else if (code >= MAP_SIZE) begin
                     push_event(kscd_pkg::KIND_BEYOND, 7'd0, kscd_pkg::DIR_UP, code);
                  end else begin
                     if (shift_holds != 2'd0) ch = shifted_map[code];
                     else if (caps_locked) ch = caps_map[code];
                     else ch = plain_map[code];
                     push_event(kscd_pkg::KIND_CHAR, ch, kscd_pkg::DIR_UP, code);
                  end
               end
            endcase
         end
      endfunction

      task report(input string field, input int unsigned got, input int unsigned want,
                  input logic [7:0] code);
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (scan byte 0x%02h)",
                  $realtime, field, got, want, code);
         mismatch_count++;
      endtask

      // Accepted response: compare with the oldest queued event
      task check_key_event(input key_event_type got);
         key_event_type want;
         if (pending_events.size() == 0) begin
            report("unexpected response", got.kind, 0, got.raw_code);
         end else begin
            want = pending_events.pop_front();
            if (got.kind !== want.kind)
               report("event_kind", got.kind, want.kind, want.raw_code);
            if (got.char_code !== want.char_code)
               report("char_code", got.char_code, want.char_code, want.raw_code);
            if (got.arrow_dir !== want.arrow_dir)
               report("arrow_dir", got.arrow_dir, want.arrow_dir, want.raw_code);
            if (got.shift_on !== want.shift_on)
               report("shift_active", got.shift_on, want.shift_on, want.raw_code);
            if (got.ctrl_on !== want.ctrl_on)
               report("ctrl_active", got.ctrl_on, want.ctrl_on, want.raw_code);
            if (got.alt_on !== want.alt_on)
               report("alt_active", got.alt_on, want.alt_on, want.raw_code);
            if (got.cmd_on !== want.cmd_on)
               report("cmd_active", got.cmd_on, want.cmd_on, want.raw_code);
            if (got.caps_on !== want.caps_on)
               report("caps_active", got.caps_on, want.caps_on, want.raw_code);
            if (got.raw_code !== want.raw_code)
               report("raw_code", got.raw_code, want.raw_code, want.raw_code);
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_scan_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_event_kind;
   logic [6:0] rsp_char_code;
   logic [1:0] rsp_arrow_dir;
   logic       rsp_shift_active;
   logic       rsp_ctrl_active;
   logic       rsp_alt_active;
   logic       rsp_cmd_active;
   logic       rsp_caps_active;
   logic [7:0] rsp_raw_code;

   key_event_tracker_type decoder_model;
   int unsigned           bytes_sent = 0;
   int unsigned           cycle_count = 0;
   int unsigned           stall_pct = 0;
   logic                  sender_idles = 1'b0;
   logic                  hold_off_now = 1'b0;

   keyboard_scan_code_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_byte    (req_scan_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_char_code    (rsp_char_code),
      .rsp_arrow_dir    (rsp_arrow_dir),
      .rsp_shift_active (rsp_shift_active),
      .rsp_ctrl_active  (rsp_ctrl_active),
      .rsp_alt_active   (rsp_alt_active),
      .rsp_cmd_active   (rsp_cmd_active),
      .rsp_caps_active  (rsp_caps_active),
      .rsp_raw_code     (rsp_raw_code)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Handshake monitor: both channels sampled at the edge
   always @(posedge clock) begin
      key_event_type seen;
      if (!reset) begin
         if (req_valid && !req_stall)
            decoder_model.predict_scan_byte(req_scan_byte);
         if (rsp_valid && !rsp_stall) begin
            seen.kind      = kscd_pkg::kind_type'(rsp_event_kind);
            seen.char_code = rsp_char_code;
            seen.arrow_dir = rsp_arrow_dir;
            seen.shift_on  = rsp_shift_active;
            seen.ctrl_on   = rsp_ctrl_active;
            seen.alt_on    = rsp_alt_active;
            seen.cmd_on    = rsp_cmd_active;
            seen.caps_on   = rsp_caps_active;
            seen.raw_code  = rsp_raw_code;
            decoder_model.check_key_event(seen);
         end
      end
   end

   // Response side: random stalls, occasional runs, one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 19) == 0)
               repeat ($urandom_range(4, 30)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!sender_idles || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Offer one request and hold it until taken, then maybe idle
   task automatic send_byte(input logic [7:0] code);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_scan_byte <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_modifier();
      case ($urandom_range(0, 8))
         0: return kscd_pkg::SC_LSHIFT_MAKE;
         1: return kscd_pkg::SC_RSHIFT_MAKE;
         2: return kscd_pkg::SC_LSHIFT_BRK;
         3: return kscd_pkg::SC_RSHIFT_BRK;
         4: return kscd_pkg::SC_CTRL_MAKE;
         5: return kscd_pkg::SC_CTRL_BRK;
         6: return kscd_pkg::SC_ALT_MAKE;
         7: return kscd_pkg::SC_ALT_BRK;
         default: return kscd_pkg::SC_CAPS_MAKE;
      endcase
   endfunction

   function automatic logic [7:0] pick_extended();
      case ($urandom_range(0, 14))
         0: return kscd_pkg::SC_LCMD_MAKE;
         1: return kscd_pkg::SC_RCMD_MAKE;
         2: return kscd_pkg::SC_LCMD_BRK;
         3: return kscd_pkg::SC_RCMD_BRK;
         4: return kscd_pkg::SC_CTRL_MAKE;
         5: return kscd_pkg::SC_CTRL_BRK;
         6: return kscd_pkg::SC_UP_MAKE;
         7: return kscd_pkg::SC_LEFT_MAKE;
         8: return kscd_pkg::SC_RIGHT_MAKE;
         9: return kscd_pkg::SC_DOWN_MAKE;
         10: return kscd_pkg::SC_UP_BRK;
         11: return kscd_pkg::SC_LEFT_BRK;
         12: return kscd_pkg::SC_RIGHT_BRK;
         13: return kscd_pkg::SC_DOWN_BRK;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed keystrokes, some noise
   task automatic send_random_keystroke();
      int unsigned roll;
      logic [7:0]  key;
      roll = $urandom_range(0, 99);
      key  = 8'($urandom_range(0, MAP_SIZE - 1));
      if (roll < 40) begin
         send_byte(key);
         if ($urandom_range(0, 1) == 1) send_byte(key | RELEASE_BIT);
      end else if (roll < 55) begin
         send_byte(pick_modifier());
      end else if (roll < 70) begin
         send_byte(kscd_pkg::SC_PREFIX);
         send_byte(pick_extended());
      end else if (roll < 74) begin
         send_byte(kscd_pkg::SC_NUMLOCK);
      end else if (roll < 78) begin
         send_byte(SC_ACK);
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   initial begin
      logic [7:0]  opening [0:23];
      int unsigned phase_end;
      logic        pressure_done;
      opening = '{
         8'h00, 8'h39, kscd_pkg::SC_CAPS_MAKE, 8'h10, 8'h02,
         kscd_pkg::SC_LSHIFT_BRK, 8'h10, 8'h02,
         kscd_pkg::SC_ALT_MAKE, kscd_pkg::SC_CTRL_MAKE, kscd_pkg::SC_PREFIX,
         kscd_pkg::SC_LCMD_MAKE, kscd_pkg::SC_PREFIX, kscd_pkg::SC_UP_MAKE,
         kscd_pkg::SC_PREFIX, kscd_pkg::SC_DOWN_BRK, kscd_pkg::SC_PREFIX,
         kscd_pkg::SC_PREFIX, kscd_pkg::SC_NUMLOCK, 8'h3A + 8'h01,
         8'h7F, SC_ACK, RELEASE_BIT, 8'hFF};
      decoder_model = new();
      pressure_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: map edges, special codes, caps and shift interplay
      stall_pct    = 20;
      sender_idles = 1'b1;
      foreach (opening[i]) send_byte(opening[i]);
      // wrap the shift count back to zero from below
      send_byte(kscd_pkg::SC_LSHIFT_MAKE);
      send_byte(8'h1E);

      // Random phases with varying pressure on both sides
      while (bytes_sent < RANDOM_BYTES) begin
         phase_end    = bytes_sent + PHASE_BYTES;
         sender_idles = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 30;
            default: stall_pct = 60;
         endcase
         if (!pressure_done && bytes_sent > RANDOM_BYTES / 3) begin
            // receiver stops for a long stretch while requests keep coming
            pressure_done = 1'b1;
            sender_idles  = 1'b0;
            hold_off_now  = 1'b1;
         end
         while (bytes_sent < phase_end) send_random_keystroke();
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      @(posedge clock);
      while (decoder_model.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoder_model.mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
rtl/kscd_pkg.sv
rtl/kscd_decode.sv
rtl/keyboard_scan_code_decoder.sv
verif/testbench.sv
